[sv/second_order_state_space_step_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the second-order state-space step block
// Each macro names its check and samples on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef SECOND_ORDER_STATE_SPACE_STEP_DEFINES_SVH
`define SECOND_ORDER_STATE_SPACE_STEP_DEFINES_SVH

// Same-cycle implication
`define SOSS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication
`define SOSS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[sv/soss_pkg.sv]
// ----------------------------------------------------------------------------
// soss_pkg
// Types, register indexes, reset values and fixed-point helpers for the
// second-order state-space step block.
// ----------------------------------------------------------------------------
package soss_pkg;

  // Width of a result accumulated from up to three truncated products
  localparam int AccW = 42;

  // Configuration register indexes
  localparam logic [1:0] REG_STEP_GAIN      = 2'd0;
  localparam logic [1:0] REG_STIFFNESS_COEF = 2'd1;
  localparam logic [1:0] REG_DAMPING_COEF   = 2'd2;
  localparam logic [1:0] REG_OUTPUT_GAIN    = 2'd3;

  // Register reset values
  localparam logic signed [31:0] STEP_GAIN_RST      = 32'sd0;
  localparam logic signed [31:0] STIFFNESS_COEF_RST = 32'sd0;
  localparam logic signed [31:0] DAMPING_COEF_RST   = 32'sd16777216;
  localparam logic signed [31:0] OUTPUT_GAIN_RST    = 32'sd65536;

  // Input item op codes
  localparam logic OP_STEP = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  typedef struct packed {
    logic               op;
    logic signed [31:0] drive_value;
    logic signed [31:0] set_position;
    logic signed [31:0] set_velocity;
  } soss_in_t;

  typedef struct packed {
    logic signed [31:0] output_value;
    logic signed [31:0] new_position;
    logic signed [31:0] new_velocity;
    logic               saturated;
  } soss_out_t;

  // Q8.24 times Q16.16 down to Q16.16, rounded toward zero
  function automatic logic signed [39:0] trunc_q24(input logic signed [63:0] p);
    logic signed [63:0] adj;
    adj = p + (p[63] ? 64'sd16777215 : 64'sd0);
    return adj[63:24];
  endfunction

  // Q16.16 times Q16.16 down to Q16.16, rounded toward zero
  function automatic logic signed [47:0] trunc_q16(input logic signed [63:0] p);
    logic signed [63:0] adj;
    adj = p + (p[63] ? 64'sd65535 : 64'sd0);
    return adj[63:16];
  endfunction

  // True when a value lies outside the signed 32-bit range
  function automatic logic sat_hit(input logic signed [47:0] v);
    return (!v[47] && (|v[46:31])) || (v[47] && !(&v[46:31]));
  endfunction

  // Clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (!v[47] && (|v[46:31])) begin
      r = 32'sh7fffffff;
    end else if (v[47] && !(&v[46:31])) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[sv/second_order_state_space_step.sv]
// ----------------------------------------------------------------------------
// second_order_state_space_step
// A load word gives no result. A step word stalls the input until its result is
// loaded into the result register: five products go one after another through a
// single registered 32x32 signed multiplier, and the truncate, accumulate and
// clamp work for each product is done in the state that follows it.
// The input stalls while a step is in flight; a finished result waits in the
// output register and a new word may be taken meanwhile, but the next step
// holds in its last cycle until that register is free. Configuration writes
// are always ready.
// ----------------------------------------------------------------------------
module second_order_state_space_step
  import soss_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  soss_in_t         in_word,
  output logic             out_valid,
  input  logic             out_stall,
  output soss_out_t        out_word,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [31:0]      cfg_data
);

  `include "second_order_state_space_step_defines.svh"

  typedef enum logic [2:0] {
    S_IDLE, S_M0, S_M1, S_M2, S_M3, S_M4, S_FIN
  } state_t;

  state_t state;

  // Coefficients
  logic signed [31:0] step_gain;
  logic signed [31:0] stiffness_coef;
  logic signed [31:0] damping_coef;
  logic signed [31:0] output_gain;

  // System state and step working registers
  logic signed [31:0]     position;
  logic signed [31:0]     velocity;
  logic signed [31:0]     drive;
  logic signed [31:0]     np;
  logic signed [63:0]     prod;
  logic signed [AccW-1:0] acc_p;
  logic signed [AccW-1:0] acc_v;
  logic                   sat;

  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [39:0] t24;
  logic signed [47:0] t16;
  logic signed [47:0] acc_p_ext;
  logic signed [47:0] acc_v_ext;
  logic               in_take;
  logic               load_take;
  logic               fin_go;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_take   = in_valid && !in_stall;
  assign load_take = in_take && (in_word.op == OP_LOAD);
  assign fin_go    = (state == S_FIN) && (!out_valid || !out_stall);

  assign t24       = trunc_q24(prod);
  assign t16       = trunc_q16(prod);
  assign acc_p_ext = {{(48 - AccW){acc_p[AccW-1]}}, acc_p};
  assign acc_v_ext = {{(48 - AccW){acc_v[AccW-1]}}, acc_v};

  // Select multiplier operands for each step of the sequence
  always_comb begin
    mul_a = step_gain;
    mul_b = velocity;
    case (state)
      S_M0: begin
        mul_a = step_gain;
        mul_b = velocity;
      end
      S_M1: begin
        mul_a = stiffness_coef;
        mul_b = position;
      end
      S_M2: begin
        mul_a = damping_coef;
        mul_b = velocity;
      end
      S_M3: begin
        mul_a = step_gain;
        mul_b = drive;
      end
      S_M4: begin
        mul_a = output_gain;
        mul_b = np;
      end
      default: begin
        mul_a = step_gain;
        mul_b = velocity;
      end
    endcase
  end

  // Shared multiplier: register one product per sequence step
  always_ff @(posedge clk) begin
    if (state == S_M0 || state == S_M1 || state == S_M2 ||
        state == S_M3 || state == S_M4) begin
      prod <= mul_a * mul_b;
    end
  end

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      step_gain      <= STEP_GAIN_RST;
      stiffness_coef <= STIFFNESS_COEF_RST;
      damping_coef   <= DAMPING_COEF_RST;
      output_gain    <= OUTPUT_GAIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_STEP_GAIN:      step_gain      <= cfg_data;
        REG_STIFFNESS_COEF: stiffness_coef <= cfg_data;
        REG_DAMPING_COEF:   damping_coef   <= cfg_data;
        REG_OUTPUT_GAIN:    output_gain    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer, state update and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      position  <= '0;
      velocity  <= '0;
      out_valid <= 1'b0;
    end else begin
      // load a finished result, else drop the word once it is taken
      if (fin_go) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_take) begin
            if (in_word.op == OP_LOAD) begin
              position <= in_word.set_position;
              velocity <= in_word.set_velocity;
            end else begin
              drive <= in_word.drive_value;
              state <= S_M0;
            end
          end
        end
        S_M0: state <= S_M1;
        S_M1: begin
          // position plus dt times velocity
          acc_p <= AccW'(position) + AccW'(t24);
          state <= S_M2;
        end
        S_M2: begin
          np    <= sat32(acc_p_ext);
          sat   <= sat_hit(acc_p_ext);
          acc_v <= AccW'(t24);
          state <= S_M3;
        end
        S_M3: begin
          acc_v <= acc_v + AccW'(t24);
          state <= S_M4;
        end
        S_M4: begin
          acc_v <= acc_v + AccW'(t24);
          state <= S_FIN;
        end
        S_FIN: begin
          // hold until the result register is free
          if (fin_go) begin
            position               <= np;
            velocity               <= sat32(acc_v_ext);
            out_word.output_value  <= sat32(t16);
            out_word.new_position  <= np;
            out_word.new_velocity  <= sat32(acc_v_ext);
            out_word.saturated     <= sat || sat_hit(acc_v_ext) || sat_hit(t16);
            state                  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SOSS_ASSERT_SAME(a_busy_stalls, state != S_IDLE, in_stall)
  `SOSS_ASSERT_NEXT(a_step_starts, in_take && in_word.op == OP_STEP, state == S_M0)
  `SOSS_ASSERT_NEXT(a_load_pos, load_take, position == $past(in_word.set_position))
  `SOSS_ASSERT_NEXT(a_load_vel, load_take, velocity == $past(in_word.set_velocity))
  `SOSS_ASSERT_SAME(a_result_from_fin, $rose(out_valid), $past(state) == S_FIN)

endmodule
